@@ hdl/assert_macros.svh @@
// assertion macros shared by the tuner rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define LSAT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the condition, outside reset
`define LSAT_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hdl/lsat_pkg.sv @@
// types and constants for the lightning sensor auto tuner
// used by lightning_sensor_auto_tuner_core; no dependencies
package lsat_pkg;

    localparam int NOISE_W   = 3;
    localparam int LEVEL_W   = 4;
    localparam int HOLD_W    = 20;
    localparam int SRC_W     = 3;
    localparam int DIST_W    = 6;
    localparam int STORM_W   = 2;
    localparam int MASK_W    = 3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [NOISE_W-1:0] NOISE_MAX    = 3'd7;
    localparam logic [LEVEL_W-1:0] WATCHDOG_MAX = 4'd15;
    localparam logic [LEVEL_W-1:0] SPIKE_MAX    = 4'd15;

    localparam logic [NOISE_W-1:0] NOISE_RESET    = 3'd2;
    localparam logic [LEVEL_W-1:0] WATCHDOG_RESET = 4'd2;
    localparam logic [LEVEL_W-1:0] SPIKE_RESET    = 4'd2;

    localparam logic [HOLD_W-1:0] NOISE_HOLD_RESET = 20'd5000;
    localparam logic [HOLD_W-1:0] QUIET_HOLD_RESET = 20'd60000;

    // configuration register indexes
    localparam logic REG_NOISE_HOLD = 1'b0;
    localparam logic REG_QUIET_HOLD = 1'b1;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    // interrupt sources
    localparam logic [SRC_W-1:0] SRC_NOISE     = 3'd0;
    localparam logic [SRC_W-1:0] SRC_DISTURBER = 3'd1;
    localparam logic [SRC_W-1:0] SRC_LIGHTNING = 3'd2;
    localparam logic [SRC_W-1:0] SRC_DISTANCE  = 3'd3;

    // storm event codes
    localparam logic [STORM_W-1:0] STORM_NONE      = 2'd0;
    localparam logic [STORM_W-1:0] STORM_LIGHTNING = 2'd1;
    localparam logic [STORM_W-1:0] STORM_DISTANCE  = 2'd2;

    // changed mask bits
    localparam int CHG_NOISE    = 0;
    localparam int CHG_WATCHDOG = 1;
    localparam int CHG_SPIKE    = 2;

    typedef struct packed {
        logic [DIST_W-1:0]  storm_distance_km;
        logic               at_limit;
        logic [MASK_W-1:0]  changed_mask;
        logic [LEVEL_W-1:0] spike_reject_level;
        logic [LEVEL_W-1:0] watchdog_level;
        logic [NOISE_W-1:0] noise_floor;
    } result_t;

endpackage

@@ hdl/lightning_sensor_auto_tuner_core.sv @@
// lightning sensor auto tuner: input register, one pass of update logic, result register
// depends on lsat_pkg and assert_macros.svh
//
// usage:
//   s_* channel takes one request per transaction: s_tuser holds the request kind
//   (0 one-millisecond tick, 1 sensor interrupt), s_tdata the interrupt source and distance.
//   m_* channel returns exactly one result per request, in order: the three levels after
//   the request, the changed mask, the limit flag and the storm distance in m_tdata,
//   the storm event code in m_tuser.
//   cfg_* channel writes the noise hold (index 0) or quiet hold (index 1); cfg_ready is
//   always high and writes are expected only while no request is in flight.
// timing:
//   an s transaction reaches m_tvalid via the input and result registers; one request per cycle
//   is sustained with m_tready high, the level and counter update being one compare/increment pass.
// reset:
//   levels return to 2, both counters to 0, holds to 5000 and 60000 ms, pipeline empties.
// stall:
//   while m_tready is low the result holds; the input register still takes one more
//   request, then s_tready drops until the result is taken.
`include "assert_macros.svh"

module lightning_sensor_auto_tuner_core
    import lsat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // int_source[2:0], distance_km[8:3], zero pad
    input  logic                 s_tuser,   // req_type[0]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // noise_floor[2:0], watchdog_level[6:3],
                                            // spike_reject_level[10:7], changed_mask[13:11],
                                            // at_limit[14], storm_distance_km[20:15], zero pad
    output logic [STORM_W-1:0]   m_tuser,   // storm_event[1:0]

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [HOLD_W-1:0]    cfg_data
);

    // configuration
    logic [HOLD_W-1:0]  noise_hold_reg;
    logic [HOLD_W-1:0]  quiet_hold_reg;

    // input stage
    logic               in_valid_reg;
    logic               in_req_reg;
    logic [SRC_W-1:0]   in_src_reg;
    logic [DIST_W-1:0]  in_dist_reg;

    // tuner state
    logic [NOISE_W-1:0] noise_level_reg,  noise_level_next;
    logic [LEVEL_W-1:0] watchdog_reg,     watchdog_next;
    logic [LEVEL_W-1:0] spike_reg,        spike_next;
    logic [HOLD_W-1:0]  noise_cnt_reg,    noise_cnt_next;
    logic [HOLD_W-1:0]  quiet_cnt_reg,    quiet_cnt_next;

    // result stage
    logic               out_valid_reg;
    result_t            res_reg, res_next;
    logic [STORM_W-1:0] storm_reg;

    logic               advance;
    logic               s_accept;
    logic               is_tick;
    logic               is_event;
    logic [HOLD_W:0]    noise_inc;
    logic [HOLD_W:0]    quiet_inc;
    logic               noise_fire;
    logic               quiet_fire;
    logic [MASK_W-1:0]  changed;
    logic               limit;
    logic [STORM_W-1:0] storm;
    logic [DIST_W-1:0]  sdist;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - $bits(result_t)){1'b0}}, res_reg};
    // m_tuser comes from the registered storm code
    assign m_tuser   = storm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_hold_reg <= NOISE_HOLD_RESET;
            quiet_hold_reg <= QUIET_HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_NOISE_HOLD)
            begin
                noise_hold_reg <= cfg_data;
            end
            if (cfg_index == REG_QUIET_HOLD)
            begin
                quiet_hold_reg <= cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_req_reg  <= s_tuser;
            in_src_reg  <= s_tdata[SRC_W-1:0];
            in_dist_reg <= s_tdata[SRC_W+DIST_W-1:SRC_W];
        end
    end

    // update logic
    assign is_tick   = (in_req_reg == REQ_TICK);
    assign is_event  = (in_req_reg == REQ_EVENT);
    assign noise_inc = {1'b0, noise_cnt_reg} + {{HOLD_W{1'b0}}, 1'b1};
    assign quiet_inc = {1'b0, quiet_cnt_reg} + {{HOLD_W{1'b0}}, 1'b1};
    assign noise_fire = noise_inc > {1'b0, noise_hold_reg};
    assign quiet_fire = quiet_inc > {1'b0, quiet_hold_reg};

    always_comb
    begin
        noise_level_next = noise_level_reg;
        watchdog_next    = watchdog_reg;
        spike_next       = spike_reg;
        noise_cnt_next   = noise_cnt_reg;
        quiet_cnt_next   = quiet_cnt_reg;
        changed          = '0;
        limit            = 1'b0;
        storm            = STORM_NONE;
        sdist            = '0;

        if (is_tick)
        begin
            noise_cnt_next = noise_fire ? '0 : noise_inc[HOLD_W-1:0];
            quiet_cnt_next = quiet_fire ? '0 : quiet_inc[HOLD_W-1:0];
            if (noise_fire && noise_level_reg != '0)
            begin
                noise_level_next    = noise_level_reg - 1'b1;
                changed[CHG_NOISE]  = 1'b1;
            end
            if (quiet_fire)
            begin
                if (watchdog_reg > spike_reg)
                begin
                    watchdog_next         = watchdog_reg - 1'b1;
                    changed[CHG_WATCHDOG] = 1'b1;
                end
                else if (spike_reg != '0)
                begin
                    spike_next         = spike_reg - 1'b1;
                    changed[CHG_SPIKE] = 1'b1;
                end
            end
        end
        else
        begin
            case (in_src_reg)
                SRC_NOISE:
                begin
                    noise_cnt_next = '0;
                    if (noise_level_reg < NOISE_MAX)
                    begin
                        noise_level_next   = noise_level_reg + 1'b1;
                        changed[CHG_NOISE] = 1'b1;
                    end
                    else if (watchdog_reg < WATCHDOG_MAX)
                    begin
                        watchdog_next         = watchdog_reg + 1'b1;
                        changed[CHG_WATCHDOG] = 1'b1;
                    end
                    else
                    begin
                        limit = 1'b1;
                    end
                end
                SRC_DISTURBER:
                begin
                    quiet_cnt_next = '0;
                    // raise whichever of watchdog and spike rejection is not larger, watchdog on a tie
                    if (watchdog_reg <= spike_reg)
                    begin
                        if (watchdog_reg < WATCHDOG_MAX)
                        begin
                            watchdog_next         = watchdog_reg + 1'b1;
                            changed[CHG_WATCHDOG] = 1'b1;
                        end
                        else
                        begin
                            limit = 1'b1;
                        end
                    end
                    else if (spike_reg < SPIKE_MAX)
                    begin
                        spike_next         = spike_reg + 1'b1;
                        changed[CHG_SPIKE] = 1'b1;
                    end
                    else
                    begin
                        limit = 1'b1;
                    end
                end
                SRC_LIGHTNING:
                begin
                    storm = STORM_LIGHTNING;
                    sdist = in_dist_reg;
                end
                SRC_DISTANCE:
                begin
                    storm = STORM_DISTANCE;
                    sdist = in_dist_reg;
                end
                default:
                begin
                    storm = STORM_NONE;
                end
            endcase
        end

        res_next.noise_floor        = noise_level_next;
        res_next.watchdog_level     = watchdog_next;
        res_next.spike_reject_level = spike_next;
        res_next.changed_mask       = changed;
        res_next.at_limit           = limit;
        res_next.storm_distance_km  = sdist;
    end

    // state commits when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_level_reg <= NOISE_RESET;
            watchdog_reg    <= WATCHDOG_RESET;
            spike_reg       <= SPIKE_RESET;
            noise_cnt_reg   <= '0;
            quiet_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            noise_level_reg <= noise_level_next;
            watchdog_reg    <= watchdog_next;
            spike_reg       <= spike_next;
            noise_cnt_reg   <= noise_cnt_next;
            quiet_cnt_reg   <= quiet_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg   <= res_next;
            storm_reg <= storm;
        end
    end

    logic unused_is_event;
    assign unused_is_event = is_event;

    // assertions
    `LSAT_ASSERT(a_full_blocks_input,
        !(in_valid_reg && out_valid_reg && !m_tready && s_tready),
        "input accepted while both stages are full and stalled")
    `LSAT_ASSERT(a_limit_no_change,
        !(out_valid_reg && res_reg.at_limit && res_reg.changed_mask != '0),
        "limit flagged together with a level change")
    `LSAT_ASSERT(a_storm_no_change,
        !(out_valid_reg && storm_reg != STORM_NONE &&
          (res_reg.changed_mask != '0 || res_reg.at_limit)),
        "storm event reported with a level change")
    `LSAT_ASSERT(a_no_storm_zero_dist,
        !(out_valid_reg && storm_reg == STORM_NONE && res_reg.storm_distance_km != '0),
        "distance reported without a storm event")
    `LSAT_ASSERT_NEXT(a_commit_tracks_result, advance,
        res_reg.noise_floor == noise_level_reg && res_reg.watchdog_level == watchdog_reg &&
        res_reg.spike_reject_level == spike_reg,
        "result levels differ from committed state")

endmodule
